FILE: design/particle_euler_update_top_macros.svh
// Assertion macros for the particle update block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef PARTICLE_EULER_UPDATE_TOP_MACROS_SVH
`define PARTICLE_EULER_UPDATE_TOP_MACROS_SVH

// pre implies post on the same edge
`define PEU_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// cond never holds
`define PEU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: design/peu_pkg.sv
// Shared types and constants for the particle update block.
// No dependencies.
package peu_pkg;

    typedef enum logic [1:0] {
        KIND_DEAD  = 2'd0,
        KIND_ALIVE = 2'd1,
        KIND_DIED  = 2'd2
    } t_kind;

    localparam logic [1:0] CFG_FRAME_STEP = 2'd0;
    localparam logic [1:0] CFG_CAMERA_X   = 2'd1;
    localparam logic [1:0] CFG_CAMERA_Y   = 2'd2;
    localparam logic [1:0] CFG_CAMERA_Z   = 2'd3;

    localparam logic [15:0] FRAME_STEP_RESET = 16'd1049;
    // half gravity, Q16.16
    localparam logic signed [32:0] GRAV_HALF = -33'sd321454;
    localparam logic [31:0] DIST_DIED = 32'hFFFF0000;
    localparam logic [31:0] Q16_MAX   = 32'h7FFFFFFF;
    localparam logic [31:0] Q16_MIN   = 32'h80000000;

    typedef struct packed {
        t_kind            kind;
        logic [15:0]      slot;
        logic [31:0]      life;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [31:0]      size;
        logic [31:0]      colour;
    } t_item;

    typedef struct packed {
        t_item       item;
        logic [31:0] cam_dist;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: design/particle_euler_update_top.sv
// Particle update block: Euler step, life decay, slotting and camera distance.
// A dead or just-died particle skips the arithmetic; a live one runs the Euler step and distance.
// The back end handles one transaction at a time, using its shared multiplier for the
// Euler step and its one-bit-per-cycle square root for the camera distance.
// Synchronous active-low reset clears control, slot count and config to defaults.
// Depends on peu_pkg, peu_front, peu_queue, peu_back and the macros header.
`include "particle_euler_update_top_macros.svh"

module particle_euler_update_top #(
    parameter int POOL_SIZE = 65536
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // life, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, size, colour
    input  logic [287:0] s_axis_tdata,
    // frame_start
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot, life, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, cam_distance, size, colour
    output logic [335:0] m_axis_tdata,
    // kind
    output logic [1:0]   m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data
);
    import peu_pkg::*;

    logic [15:0]      r_frame_step;
    logic [2:0][31:0] r_cam;
    t_item   push_item, q_item;
    t_q_stat q_stat;
    t_result res;
    logic push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_step <= FRAME_STEP_RESET;
            r_cam        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FRAME_STEP: r_frame_step <= i_cfg_data[15:0];
                CFG_CAMERA_X:   r_cam[0]     <= i_cfg_data;
                CFG_CAMERA_Y:   r_cam[1]     <= i_cfg_data;
                CFG_CAMERA_Z:   r_cam[2]     <= i_cfg_data;
            endcase
        end
    end

    peu_front #(.POOL_SIZE(POOL_SIZE)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_frame_start (s_axis_tuser),
        .i_data        (s_axis_tdata),
        .i_frame_step  (r_frame_step),
        .i_q_full      (q_stat.full),
        .o_ready       (s_axis_tready),
        .o_push        (push),
        .o_item        (push_item)
    );

    peu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    peu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_empty      (q_stat.empty),
        .i_frame_step (r_frame_step),
        .i_cam        (r_cam),
        .i_ready      (m_axis_tready),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .o_result     (res)
    );

    assign m_axis_tuser = res.item.kind;
    assign m_axis_tdata = {res.item.colour, res.item.size, res.cam_dist,
                           res.item.vel[2], res.item.vel[1], res.item.vel[0],
                           res.item.pos[2], res.item.pos[1], res.item.pos[0],
                           res.item.life, res.item.slot};

    `PEU_ASSERT_NEVER(a_queue_state, q_stat.full && q_stat.empty, "queue full and empty")
    `PEU_ASSERT_IMPLY(a_dead_slot, m_axis_tvalid && m_axis_tuser == KIND_DEAD,
        m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[271:240] == 32'd0, "dead result not clean")
    `PEU_ASSERT_IMPLY(a_died_dist, m_axis_tvalid && m_axis_tuser == KIND_DIED,
        m_axis_tdata[271:240] == DIST_DIED, "died result distance wrong")

endmodule

FILE: design/peu_front.sv
// Front end: accepts particle transactions, updates life, classifies and assigns slots.
// Depends on peu_pkg.
module peu_front #(
    parameter int POOL_SIZE = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_frame_start,
    input  logic [287:0]   i_data,
    input  logic [15:0]    i_frame_step,
    input  logic           i_q_full,
    output logic           o_ready,
    output logic           o_push,
    output peu_pkg::t_item o_item
);
    import peu_pkg::*;

    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam logic [CW-1:0] POOL_C  = CW'(POOL_SIZE);
    localparam logic [CW-1:0] POOL_M1 = CW'(POOL_SIZE - 1);

    logic [CW-1:0] r_cnt, n_cnt, cnt_base, slot_w;
    logic signed [31:0] life, life_new;
    logic alive_in;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        life     = $signed(i_data[31:0]);
        life_new = life - $signed({16'd0, i_frame_step});
        alive_in = life > 32'sd0;
        cnt_base = i_frame_start ? '0 : r_cnt;
        slot_w   = '0;
        n_cnt    = cnt_base;
        if (alive_in) begin
            if (cnt_base < POOL_C) begin
                slot_w = cnt_base;
                n_cnt  = cnt_base + CW'(1);
            end else begin
                slot_w = POOL_M1;
            end
        end
        o_item.pos    = i_data[127:32];
        o_item.vel    = i_data[223:128];
        o_item.size   = i_data[255:224];
        o_item.colour = i_data[287:256];
        o_item.slot   = 16'(slot_w);
        if (!alive_in) begin
            o_item.kind = KIND_DEAD;
            o_item.life = life;
        end else if (life_new > 32'sd0) begin
            o_item.kind = KIND_ALIVE;
            o_item.life = life_new;
        end else begin
            o_item.kind = KIND_DIED;
            o_item.life = life_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: design/peu_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on peu_pkg.
module peu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  peu_pkg::t_item   i_item,
    input  logic             i_pop,
    output peu_pkg::t_item   o_item,
    output peu_pkg::t_q_stat o_stat
);
    import peu_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_item       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: design/peu_back.sv
// Back end: Euler step on one shared multiplier, squared distance, bit-serial square root.
// Depends on peu_pkg.
module peu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  peu_pkg::t_item     i_item,
    input  logic               i_empty,
    input  logic [15:0]        i_frame_step,
    input  logic [2:0][31:0]   i_cam,
    input  logic               i_ready,
    output logic               o_pop,
    output logic               o_valid,
    output peu_pkg::t_result   o_result
);
    import peu_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ADD  = 7'b0000100,
        S_SQ   = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_ROOT = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_item  r_item, n_item;
    logic [1:0] r_step, n_step, ax;
    logic signed [49:0] r_prod, n_prod;
    logic [61:0] r_sq, n_sq;
    logic [63:0] r_sum, n_sum;
    logic r_sat, n_sat;
    logic [34:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [4:0] r_iter, n_iter;
    logic [31:0] r_dist, n_dist;
    logic r_ovalid, n_ovalid;
    t_result r_out, n_out;

    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic [49:0] pmag;
    logic [33:0] rnd;
    logic signed [34:0] delta, base, upd;
    logic [31:0] upd_sat;
    logic signed [32:0] diff;
    logic [32:0] dmag;
    logic [34:0] rem_sh, trial;
    logic [31:0] dist_w;

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

    always_comb begin
        ax    = r_step - 2'd1;
        mul_a = (r_step == 2'd0) ? GRAV_HALF
                                 : $signed({r_item.vel[ax][31], r_item.vel[ax]});
        mul_b = $signed({1'b0, i_frame_step});

        pmag  = r_prod[49] ? 50'(-r_prod) : 50'(r_prod);
        rnd   = 34'((pmag + 50'h8000) >> 16);
        delta = r_prod[49] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
        base  = (r_step == 2'd0) ? $signed({{3{r_item.vel[1][31]}}, r_item.vel[1]})
                                 : $signed({{3{r_item.pos[ax][31]}}, r_item.pos[ax]});
        upd   = base + delta;
        if (upd[34:31] == 4'b0000 || upd[34:31] == 4'b1111) begin
            upd_sat = upd[31:0];
        end else begin
            upd_sat = upd[34] ? Q16_MIN : Q16_MAX;
        end

        diff = $signed({r_item.pos[r_step][31], r_item.pos[r_step]})
             - $signed({i_cam[r_step][31], i_cam[r_step]});
        dmag = diff[32] ? 33'(-diff) : 33'(diff);

        rem_sh = {r_rem[32:0], r_sum[63:62]};
        trial  = {1'b0, r_root, 2'b01};

        if (r_item.kind == KIND_ALIVE) begin
            dist_w = (r_sat || r_root[31]) ? Q16_MAX : r_root;
        end else begin
            dist_w = r_dist;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_step   = r_step;
        n_prod   = r_prod;
        n_sq     = r_sq;
        n_sum    = r_sum;
        n_sat    = r_sat;
        n_rem    = r_rem;
        n_root   = r_root;
        n_iter   = r_iter;
        n_dist   = r_dist;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_ready;
        o_pop    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    n_step = 2'd0;
                    n_dist = (i_item.kind == KIND_DIED) ? DIST_DIED : 32'd0;
                    n_state = (i_item.kind == KIND_ALIVE) ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                n_prod  = mul_a * mul_b;
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_step == 2'd0) begin
                    n_item.vel[1] = upd_sat;
                end else begin
                    n_item.pos[ax] = upd_sat;
                end
                if (r_step == 2'd3) begin
                    n_step  = 2'd0;
                    n_sum   = '0;
                    n_sat   = 1'b0;
                    n_state = S_SQ;
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_SQ: begin
                if (dmag[32] || dmag[31]) begin
                    n_sat = 1'b1;
                end
                n_sq    = dmag[30:0] * dmag[30:0];
                n_state = S_ACC;
            end
            S_ACC: begin
                n_sum = r_sum + 64'(r_sq);
                if (r_step == 2'd2) begin
                    n_iter  = 5'd31;
                    n_rem   = '0;
                    n_root  = '0;
                    n_state = S_ROOT;
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = S_SQ;
                end
            end
            S_ROOT: begin
                n_sum = {r_sum[61:0], 2'b00};
                if (rem_sh >= trial) begin
                    n_rem  = rem_sh - trial;
                    n_root = {r_root[30:0], 1'b1};
                end else begin
                    n_rem  = rem_sh;
                    n_root = {r_root[30:0], 1'b0};
                end
                n_iter = r_iter - 5'd1;
                if (r_iter == 5'd0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_out.item     = r_item;
                    n_out.cam_dist = dist_w;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_step <= n_step;
        r_prod <= n_prod;
        r_sq   <= n_sq;
        r_sum  <= n_sum;
        r_sat  <= n_sat;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_iter <= n_iter;
        r_dist <= n_dist;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
